[src/ils_pkg.sv]
// Shared types and constants for the indexed list store.
package ils_pkg;

  localparam int unsigned IlsDepth = 64;

  localparam int unsigned ActionW = 2;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 7;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [ActionW-1:0] {
    ACT_APPEND = 2'd0,
    ACT_READ   = 2'd1,
    ACT_WRITE  = 2'd2,
    ACT_REMOVE = 2'd3
  } ils_action_e;

  typedef logic [WordW-1:0] ils_word_t;

  // Broadcast control to every cell of the chain.
  typedef struct packed {
    logic load;   // store the item's word at the selected position
    logic shift;  // close up the list over the selected position
  } ils_ctrl_t;

endpackage

[src/ils_cell.sv]
// One storage cell of the list chain: holds the word at a fixed position.
module ils_cell #(
  parameter int unsigned DEPTH = ils_pkg::IlsDepth,
  parameter int unsigned POS   = 0,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  ils_pkg::ils_ctrl_t ctrl_i,
  input  logic [CW-1:0]     pos_i,
  input  logic [CW-1:0]     count_i,
  input  ils_pkg::ils_word_t value_i,
  input  ils_pkg::ils_word_t next_word_i,
  output ils_pkg::ils_word_t word_o,
  output ils_pkg::ils_word_t rd_word_o
);
  import ils_pkg::*;

  localparam logic [CW-1:0] MyPos   = CW'(POS);
  localparam logic [CW-1:0] NextPos = CW'(POS + 1);

  ils_word_t word_q, word_d;
  logic      hit;

  assign hit = (pos_i == MyPos);

  always_comb begin
    word_d = word_q;
    if (ctrl_i.load && hit) begin
      word_d = value_i;
    end else if (ctrl_i.shift && (MyPos >= pos_i) && (NextPos < count_i)) begin
      // Take the neighbor's word so that later entries move one place forward.
      word_d = next_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  assign rd_word_o = hit ? word_q : '0;

endmodule

[src/ils_chain.sv]
// Row of list cells with neighbor links and the read-out combine.
module ils_chain #(
  parameter int unsigned DEPTH = ils_pkg::IlsDepth,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  ils_pkg::ils_ctrl_t ctrl_i,
  input  logic [CW-1:0]      pos_i,
  input  logic [CW-1:0]      count_i,
  input  ils_pkg::ils_word_t value_i,
  output ils_pkg::ils_word_t rd_word_o
);
  import ils_pkg::*;

  ils_word_t cell_rd [DEPTH];
  ils_word_t cell_wd [DEPTH];
  ils_word_t cell_nx [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ils_cell #(
      .DEPTH(DEPTH),
      .POS  (g),
      .CW   (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .pos_i      (pos_i),
      .count_i    (count_i),
      .value_i    (value_i),
      .next_word_i(cell_nx[g]),
      .word_o     (cell_wd[g]),
      .rd_word_o  (cell_rd[g])
    );
  end

  // Each cell sees the stored word of the cell after it; the last one sees zero.
  for (genvar g = 0; g < DEPTH; g++) begin : g_link
    if (g < DEPTH - 1) begin : g_mid
      assign cell_nx[g] = cell_wd[g+1];
    end else begin : g_end
      assign cell_nx[g] = '0;
    end
  end

  always_comb begin
    rd_word_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word_o = rd_word_o | cell_rd[i];
    end
  end

endmodule

[src/indexed_list_store_core.sv]
// Top level of the indexed list store: stream ports, count register and result stage.
// An accepted item's result is registered and on the master side in the next cycle.
// Throughput: one item per cycle while results are taken; every action, remove included,
// needs no extra steps because all cells of the chain update in parallel.
// Reset clears the word count and the result valid flag; stored words are not cleared
// and are never read before they are written.
module indexed_list_store_core #(
  parameter int unsigned DEPTH = ils_pkg::IlsDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input items.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata from bit 0 up: action[1:0], index[7:2], value[39:8].
  input  logic [ils_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Result items.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tdata from bit 0 up: ok[0], read_word[32:1], count_after[39:33].
  output logic [ils_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import ils_pkg::*;

  // Count width holds DEPTH itself; index compares run at the wider of the two.
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (CW > IndexW) ? CW : IndexW;
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  logic [CW-1:0]       count_q, count_d;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic              accept;
  ils_action_e       action;
  logic [IndexW-1:0] index;
  ils_word_t         value;
  logic              idx_ok;
  logic              ok;
  ils_ctrl_t         ctrl;
  logic [CW-1:0]     pos;
  logic [CW-1:0]     count_next;
  ils_word_t         chain_rd;
  ils_word_t         read_word;

  // The result register frees up whenever its item is taken, so a new item
  // may enter in the same cycle that the previous result leaves.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign action = ils_action_e'(s_axis_tdata_i[ActionW-1:0]);
  assign index  = s_axis_tdata_i[ActionW +: IndexW];
  assign value  = s_axis_tdata_i[ActionW + IndexW +: WordW];

  assign idx_ok = IW'(index) < IW'(count_q);

  always_comb begin
    ok         = 1'b0;
    ctrl       = '0;
    pos        = CW'(index);
    count_next = count_q;
    unique case (action)
      ACT_APPEND: begin
        // An append targets the first free cell; a full list refuses it.
        ok         = (count_q != FullCount);
        pos        = count_q;
        ctrl.load  = ok;
        count_next = ok ? count_q + CW'(1) : count_q;
      end
      ACT_READ: begin
        ok = idx_ok;
      end
      ACT_WRITE: begin
        ok        = idx_ok;
        ctrl.load = ok;
      end
      ACT_REMOVE: begin
        // Cells from the index onward take their neighbor's word.
        ok         = idx_ok;
        ctrl.shift = ok;
        count_next = ok ? count_q - CW'(1) : count_q;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    ctrl.load  = ctrl.load && accept;
    ctrl.shift = ctrl.shift && accept;
  end

  assign count_d   = accept ? count_next : count_q;
  assign read_word = (action == ACT_READ && ok) ? chain_rd : '0;

  ils_chain #(
    .DEPTH(DEPTH),
    .CW   (CW)
  ) u_chain (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .pos_i    (pos),
    .count_i  (count_q),
    .value_i  (value),
    .rd_word_o(chain_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {CountW'(count_next), read_word, ok};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
